// ===== rtl/core/bove_pkg.sv =====
// ----------------------------------------------------------------------------
// bove_pkg
// Shared types, widths and constants of the box outline vertex expander.
// ----------------------------------------------------------------------------
`default_nettype none

package bove_pkg;

  localparam int FRACTION_BITS = 8;

  localparam int CORNER_W = 16;
  localparam int COORD_W  = 24;
  localparam int COLOR_W  = 8;
  localparam int DIST_W   = 50;

  localparam int CFG_IDX_W = 2;

  // corner converted to fixed point
  localparam int LO_W   = CORNER_W + FRACTION_BITS;
  localparam int BASE_W = (LO_W > COORD_W) ? LO_W : COORD_W;
  // corner minus camera, and corner widened by the offset
  localparam int DIFF_W = BASE_W + 1;
  localparam int WIDE_W = BASE_W + 1;

  // per-axis distance magnitude is clamped to 2^25 before squaring
  localparam int CLAMP_W = 26;
  localparam int MAG_W   = (DIFF_W > CLAMP_W) ? DIFF_W : CLAMP_W;
  localparam int SQ_W    = 2 * CLAMP_W - 1;
  localparam int SUM_W   = SQ_W + 2;

  localparam logic [CLAMP_W-1:0] CLAMP_LIM = CLAMP_W'(1) << (CLAMP_W - 1);
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [DIST_W-1:0]  NEAR_LIM  = DIST_W'(1024) << (2 * FRACTION_BITS);

  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));

  localparam int OFF_NEAR = 1 << (FRACTION_BITS - 5);
  localparam int OFF_FAR  = 1 << (FRACTION_BITS - 4);

  localparam int N_VTX        = 48;
  localparam int VTX_PER_PASS = 24;
  localparam int CNT_W        = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X = 2'd0,
    CFG_CAMERA_Y = 2'd1,
    CFG_CAMERA_Z = 2'd2
  } cfg_reg_e;

  // ordered corners and color of one box
  typedef struct packed {
    logic [2:0][CORNER_W-1:0] lo;
    logic [2:0][CORNER_W-1:0] hi;
    logic [3:0][COLOR_W-1:0]  rgba;
  } box_info_t;

  // corner select per vertex, bits {x, y, z}: 1 picks the max side
  localparam logic [2:0] VTX_SEL [N_VTX] = '{
    // face quads
    3'b000, 3'b001, 3'b101, 3'b100,
    3'b010, 3'b011, 3'b111, 3'b110,
    3'b000, 3'b010, 3'b110, 3'b100,
    3'b001, 3'b011, 3'b111, 3'b101,
    3'b000, 3'b010, 3'b011, 3'b001,
    3'b100, 3'b110, 3'b111, 3'b101,
    // edge lines
    3'b000, 3'b100, 3'b100, 3'b101, 3'b101, 3'b001, 3'b001, 3'b000,
    3'b010, 3'b110, 3'b110, 3'b111, 3'b111, 3'b011, 3'b011, 3'b010,
    3'b000, 3'b010, 3'b100, 3'b110, 3'b101, 3'b111, 3'b001, 3'b011
  };

endpackage

`default_nettype wire

// ===== rtl/core/box_outline_vertex_expander.sv =====
// ----------------------------------------------------------------------------
// box_outline_vertex_expander
// Orders two block corners, finds near/far squared camera distance, widens
// the box and streams its face vertices and then its edge line vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one box: two integer corners
//   and an RGBA color. Output channel (out_valid_o/out_ready_i) gives 48
//   vertex items per box, 24 face vertices in the input color then 24 line
//   vertices with inverted RGB, last_o marking the 48th.
//   Camera position is written through cfg_we_i/cfg_index_i/cfg_wdata_i
//   while no box is in flight; index 3 is ignored.
//   A box passes five pipeline registers (ordering, squaring, sums, two
//   levels of min/max) and the emitter register before its first vertex is
//   valid; the emitter then gives one vertex per cycle while out_ready_i is
//   high. Each box holds the single output port for its 48 vertices; up to
//   five further boxes wait in the pipeline while the emitter is busy, and
//   the next box follows the previous one's last vertex with no gap.
//   When the receiver stalls, the current vertex holds and the pipeline
//   fills, after which in_ready_o drops.
//   Reset clears the camera to zero and empties the pipeline and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module box_outline_vertex_expander (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic [bove_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bove_pkg::COORD_W-1:0]       cfg_wdata_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [bove_pkg::CORNER_W-1:0] corner_a_x_i,
  input  wire logic signed [bove_pkg::CORNER_W-1:0] corner_a_y_i,
  input  wire logic signed [bove_pkg::CORNER_W-1:0] corner_a_z_i,
  input  wire logic signed [bove_pkg::CORNER_W-1:0] corner_b_x_i,
  input  wire logic signed [bove_pkg::CORNER_W-1:0] corner_b_y_i,
  input  wire logic signed [bove_pkg::CORNER_W-1:0] corner_b_z_i,
  input  wire logic [bove_pkg::COLOR_W-1:0]       red_i,
  input  wire logic [bove_pkg::COLOR_W-1:0]       green_i,
  input  wire logic [bove_pkg::COLOR_W-1:0]       blue_i,
  input  wire logic [bove_pkg::COLOR_W-1:0]       alpha_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [bove_pkg::COORD_W-1:0]     vertex_x_o,
  output logic signed [bove_pkg::COORD_W-1:0]     vertex_y_o,
  output logic signed [bove_pkg::COORD_W-1:0]     vertex_z_o,
  output logic [bove_pkg::COLOR_W-1:0]            out_red_o,
  output logic [bove_pkg::COLOR_W-1:0]            out_green_o,
  output logic [bove_pkg::COLOR_W-1:0]            out_blue_o,
  output logic [bove_pkg::COLOR_W-1:0]            out_alpha_o,
  output logic                                    is_line_o,
  output logic [bove_pkg::DIST_W-1:0]             near_dist_o,
  output logic [bove_pkg::DIST_W-1:0]             far_dist_o,
  output logic                                    last_o
);

  import bove_pkg::*;

  localparam logic signed [WIDE_W-1:0] W_MAX      = WIDE_W'(COORD_MAX);
  localparam logic signed [WIDE_W-1:0] W_MIN      = WIDE_W'(COORD_MIN);
  localparam logic signed [WIDE_W-1:0] W_OFF_NEAR = WIDE_W'(OFF_NEAR);
  localparam logic signed [WIDE_W-1:0] W_OFF_FAR  = WIDE_W'(OFF_FAR);

  function automatic logic [SQ_W-1:0] sq_of(input logic signed [DIFF_W-1:0] d);
    logic [MAG_W-1:0]     mag;
    logic [CLAMP_W-1:0]   cl;
    logic [2*CLAMP_W-1:0] p;
    mag = MAG_W'(unsigned'(d[DIFF_W-1] ? -d : d));
    cl  = (mag > MAG_W'(CLAMP_LIM)) ? CLAMP_LIM : mag[CLAMP_W-1:0];
    p   = cl * cl;
    return p[SQ_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] r;
    r = v;
    if (v > W_MAX) begin
      r = W_MAX;
    end else if (v < W_MIN) begin
      r = W_MIN;
    end
    return r[COORD_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] to_fixed(input logic [CORNER_W-1:0] c);
    return WIDE_W'(signed'(c)) <<< FRACTION_BITS;
  endfunction

  // --------------------------------------------------------------------------
  // camera registers

  logic [2:0][COORD_W-1:0] cam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CAMERA_X: cam_q[0] <= cfg_wdata_i;
        CFG_CAMERA_Y: cam_q[1] <= cfg_wdata_i;
        CFG_CAMERA_Z: cam_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when empty or when it is being drained

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic s1_take, s2_take, s3_take, s4_take, s5_take;
  logic em_load;

  assign s5_take    = !s5_vld_q || em_load;
  assign s4_take    = !s4_vld_q || s5_take;
  assign s3_take    = !s3_vld_q || s4_take;
  assign s2_take    = !s2_vld_q || s3_take;
  assign s1_take    = !s1_vld_q || s2_take;
  assign in_ready_o = s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (s1_take) s1_vld_q <= in_valid_i;
      if (s2_take) s2_vld_q <= s1_vld_q;
      if (s3_take) s3_vld_q <= s2_vld_q;
      if (s4_take) s4_vld_q <= s3_vld_q;
      if (s5_take) s5_vld_q <= s4_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: order corners per axis

  box_info_t s1_box_d, s1_box_q;

  always_comb begin
    s1_box_d.lo[0] = (corner_a_x_i < corner_b_x_i) ? corner_a_x_i : corner_b_x_i;
    s1_box_d.hi[0] = (corner_a_x_i < corner_b_x_i) ? corner_b_x_i : corner_a_x_i;
    s1_box_d.lo[1] = (corner_a_y_i < corner_b_y_i) ? corner_a_y_i : corner_b_y_i;
    s1_box_d.hi[1] = (corner_a_y_i < corner_b_y_i) ? corner_b_y_i : corner_a_y_i;
    s1_box_d.lo[2] = (corner_a_z_i < corner_b_z_i) ? corner_a_z_i : corner_b_z_i;
    s1_box_d.hi[2] = (corner_a_z_i < corner_b_z_i) ? corner_b_z_i : corner_a_z_i;
    s1_box_d.rgba  = {alpha_i, blue_i, green_i, red_i};
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) s1_box_q <= s1_box_d;
  end

  // --------------------------------------------------------------------------
  // stage 2: per-axis squared distance of both sides to the camera

  box_info_t                 s2_box_q;
  logic [2:0][1:0][SQ_W-1:0] s2_sq_d, s2_sq_q;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      s2_sq_d[ax][0] = sq_of((DIFF_W'(signed'(s1_box_q.lo[ax])) <<< FRACTION_BITS)
                             - DIFF_W'(signed'(cam_q[ax])));
      s2_sq_d[ax][1] = sq_of((DIFF_W'(signed'(s1_box_q.hi[ax])) <<< FRACTION_BITS)
                             - DIFF_W'(signed'(cam_q[ax])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      s2_box_q <= s1_box_q;
      s2_sq_q  <= s2_sq_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: squared distance of each of the eight corners

  box_info_t                 s3_box_q;
  logic [7:0][DIST_W-1:0]    s3_dist_d, s3_dist_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic [SUM_W-1:0] s;
      s = SUM_W'(s2_sq_q[0][i / 4]) + SUM_W'(s2_sq_q[1][(i / 2) % 2])
        + SUM_W'(s2_sq_q[2][i % 2]);
      s3_dist_d[i] = (s > SUM_W'(DIST_MAX)) ? DIST_MAX : s[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_take) begin
      s3_box_q  <= s2_box_q;
      s3_dist_q <= s3_dist_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: min and max over each half

  box_info_t              s4_box_q;
  logic [1:0][DIST_W-1:0] s4_min_d, s4_min_q, s4_max_d, s4_max_q;

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      logic [DIST_W-1:0] mn_a, mn_b, mx_a, mx_b;
      mn_a = (s3_dist_q[4*h]   < s3_dist_q[4*h+1]) ? s3_dist_q[4*h]   : s3_dist_q[4*h+1];
      mn_b = (s3_dist_q[4*h+2] < s3_dist_q[4*h+3]) ? s3_dist_q[4*h+2] : s3_dist_q[4*h+3];
      mx_a = (s3_dist_q[4*h]   > s3_dist_q[4*h+1]) ? s3_dist_q[4*h]   : s3_dist_q[4*h+1];
      mx_b = (s3_dist_q[4*h+2] > s3_dist_q[4*h+3]) ? s3_dist_q[4*h+2] : s3_dist_q[4*h+3];
      s4_min_d[h] = (mn_a < mn_b) ? mn_a : mn_b;
      s4_max_d[h] = (mx_a > mx_b) ? mx_a : mx_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_take) begin
      s4_box_q <= s3_box_q;
      s4_min_q <= s4_min_d;
      s4_max_q <= s4_max_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: near and far distance

  box_info_t         s5_box_q;
  logic [DIST_W-1:0] s5_near_q, s5_far_q;

  always_ff @(posedge clk_i) begin
    if (s5_take) begin
      s5_box_q  <= s4_box_q;
      s5_near_q <= (s4_min_q[0] < s4_min_q[1]) ? s4_min_q[0] : s4_min_q[1];
      s5_far_q  <= (s4_max_q[0] > s4_max_q[1]) ? s4_max_q[0] : s4_max_q[1];
    end
  end

  // --------------------------------------------------------------------------
  // emitter: widen the box on load, then step through the 48 vertices

  logic                     em_vld_q;
  logic [CNT_W-1:0]         em_cnt_q;
  logic [2:0][COORD_W-1:0]  em_lo_q, em_hi_q, em_lo_d, em_hi_d;
  logic [3:0][COLOR_W-1:0]  em_rgba_q;
  logic [DIST_W-1:0]        em_near_q, em_far_q;
  logic                     out_fire;
  logic                     em_last;
  logic signed [WIDE_W-1:0] em_off;
  logic [2:0]               vtx_sel;

  assign out_fire = out_valid_o && out_ready_i;
  assign em_last  = (em_cnt_q == CNT_W'(N_VTX - 1));
  assign em_load  = s5_vld_q && (!em_vld_q || (out_fire && em_last));

  always_comb begin
    em_off = (s5_near_q < NEAR_LIM) ? W_OFF_NEAR : W_OFF_FAR;
    for (int ax = 0; ax < 3; ax++) begin
      em_lo_d[ax] = sat_coord(to_fixed(s5_box_q.lo[ax]) - em_off);
      em_hi_d[ax] = sat_coord(to_fixed(s5_box_q.hi[ax]) + em_off);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_vld_q <= 1'b0;
      em_cnt_q <= '0;
    end else if (em_load) begin
      em_vld_q <= 1'b1;
      em_cnt_q <= '0;
    end else if (out_fire) begin
      if (em_last) begin
        em_vld_q <= 1'b0;
        em_cnt_q <= '0;
      end else begin
        em_cnt_q <= em_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load) begin
      em_lo_q   <= em_lo_d;
      em_hi_q   <= em_hi_d;
      em_rgba_q <= s5_box_q.rgba;
      em_near_q <= s5_near_q;
      em_far_q  <= s5_far_q;
    end
  end

  assign vtx_sel = VTX_SEL[em_cnt_q];

  assign out_valid_o = em_vld_q;
  assign vertex_x_o  = vtx_sel[2] ? em_hi_q[0] : em_lo_q[0];
  assign vertex_y_o  = vtx_sel[1] ? em_hi_q[1] : em_lo_q[1];
  assign vertex_z_o  = vtx_sel[0] ? em_hi_q[2] : em_lo_q[2];
  assign is_line_o   = (em_cnt_q >= CNT_W'(VTX_PER_PASS));
  // line vertices carry the inverted RGB color; alpha passes unchanged
  assign out_red_o   = is_line_o ? ~em_rgba_q[0] : em_rgba_q[0];
  assign out_green_o = is_line_o ? ~em_rgba_q[1] : em_rgba_q[1];
  assign out_blue_o  = is_line_o ? ~em_rgba_q[2] : em_rgba_q[2];
  assign out_alpha_o = em_rgba_q[3];
  assign near_dist_o = em_near_q;
  assign far_dist_o  = em_far_q;
  assign last_o      = em_vld_q && em_last;

  // --------------------------------------------------------------------------
  // assertions

  a_near_le_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (near_dist_o <= far_dist_o))
    else $error("near distance above far distance");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !em_last) |=>
      (out_valid_o && (em_cnt_q == $past(em_cnt_q) + CNT_W'(1))))
    else $error("vertex counter did not advance");

  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_load |=> (out_valid_o && (em_cnt_q == '0)))
    else $error("new box did not start at the first vertex");

  // the emitter may still step inside a box while the input is held off
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && s5_vld_q && out_valid_o && !(out_fire && em_last)))
    else $error("input stalled while the pipeline can move");

endmodule

`default_nettype wire
